FILE: rtl/aabb_cm_pkg.sv
// Shared types for the axis-aligned box contact generator.
`timescale 1ns / 1ps
`default_nettype none

package aabb_cm_pkg;

	typedef enum logic [1:0] {
		AXIS_X = 2'd0,
		AXIS_Y = 2'd1,
		AXIS_Z = 2'd2
	} axis_t;

	localparam int unsigned NUM_AXES    = 3;
	localparam int unsigned ID_BITS     = 16;
	localparam int unsigned NUM_CORNERS = 4;

	// Per-item decision handed from the pipeline to the result sequencer.
	typedef struct packed {
		logic  hit;
		axis_t axis;
		logic  neg;
	} contact_ctrl_t;

endpackage

`default_nettype wire

FILE: rtl/aabb_cm_emit.sv
// Result sequencer: turns one contact decision into one or four result transfers.
`timescale 1ns / 1ps
`default_nettype none

module aabb_cm_emit #(
	parameter int COORD_BITS = 16
) (
	input  wire  logic                            clk,
	input  wire  logic                            arst_n,
	input  wire  logic                            load,
	output       logic                            ready,
	input  wire  aabb_cm_pkg::contact_ctrl_t      ctrl,
	input  wire  logic signed [COORD_BITS:0]      face,
	input  wire  logic signed [COORD_BITS:0]      lo [aabb_cm_pkg::NUM_AXES],
	input  wire  logic signed [COORD_BITS:0]      hi [aabb_cm_pkg::NUM_AXES],
	input  wire  logic [COORD_BITS-1:0]           depth_in,
	input  wire  logic [aabb_cm_pkg::ID_BITS-1:0] id_a,
	input  wire  logic [aabb_cm_pkg::ID_BITS-1:0] id_b,
	output       logic                            strobe,
	output       logic                            hit,
	output       logic [1:0]                      normal_axis,
	output       logic                            normal_negative,
	output       logic signed [COORD_BITS:0]      point_x,
	output       logic signed [COORD_BITS:0]      point_y,
	output       logic signed [COORD_BITS:0]      point_z,
	output       logic [COORD_BITS-1:0]           depth,
	output       logic [aabb_cm_pkg::ID_BITS-1:0] id_first,
	output       logic [aabb_cm_pkg::ID_BITS-1:0] id_second,
	output       logic                            last
);

	localparam int CNT_BITS = $clog2(aabb_cm_pkg::NUM_CORNERS);

	logic                            em_v_q;
	logic [CNT_BITS-1:0]             cnt_q;
	aabb_cm_pkg::contact_ctrl_t      ctrl_q;
	logic signed [COORD_BITS:0]      face_q;
	logic signed [COORD_BITS:0]      lo_q [aabb_cm_pkg::NUM_AXES];
	logic signed [COORD_BITS:0]      hi_q [aabb_cm_pkg::NUM_AXES];
	logic [COORD_BITS-1:0]           depth_q;
	logic [aabb_cm_pkg::ID_BITS-1:0] ida_q;
	logic [aabb_cm_pkg::ID_BITS-1:0] idb_q;

	logic                            last_now;
	aabb_cm_pkg::axis_t              u_axis;
	aabb_cm_pkg::axis_t              v_axis;
	logic                            sel_u_hi;
	logic                            sel_v_hi;
	logic signed [COORD_BITS:0]      pt [aabb_cm_pkg::NUM_AXES];

	assign last_now = !ctrl_q.hit || (cnt_q == CNT_BITS'(aabb_cm_pkg::NUM_CORNERS - 1));
	assign ready    = !em_v_q || last_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			em_v_q <= 1'b0;
			cnt_q  <= '0;
		end else if (ready) begin
			em_v_q <= load;
			cnt_q  <= '0;
		end else begin
			cnt_q <= cnt_q + CNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ready && load) begin
			ctrl_q  <= ctrl;
			face_q  <= face;
			lo_q    <= lo;
			hi_q    <= hi;
			depth_q <= depth_in;
			ida_q   <= id_a;
			idb_q   <= id_b;
		end
	end

	// The two in-face axes keep their natural order.
	always_comb begin
		case (ctrl_q.axis)
			aabb_cm_pkg::AXIS_X: begin
				u_axis = aabb_cm_pkg::AXIS_Y;
				v_axis = aabb_cm_pkg::AXIS_Z;
			end
			aabb_cm_pkg::AXIS_Y: begin
				u_axis = aabb_cm_pkg::AXIS_X;
				v_axis = aabb_cm_pkg::AXIS_Z;
			end
			aabb_cm_pkg::AXIS_Z: begin
				u_axis = aabb_cm_pkg::AXIS_X;
				v_axis = aabb_cm_pkg::AXIS_Y;
			end
			default: begin
				u_axis = aabb_cm_pkg::AXIS_Y;
				v_axis = aabb_cm_pkg::AXIS_Z;
			end
		endcase
	end

	// Corners run (umin,vmin), (umax,vmin), (umax,vmax), (umin,vmax).
	assign sel_u_hi = cnt_q[CNT_BITS-1] ^ cnt_q[0];
	assign sel_v_hi = cnt_q[CNT_BITS-1];

	always_comb begin
		for (int j = 0; j < aabb_cm_pkg::NUM_AXES; j++) begin
			if (!ctrl_q.hit) begin
				pt[j] = '0;
			end else if (ctrl_q.axis == aabb_cm_pkg::axis_t'(j)) begin
				pt[j] = face_q;
			end else if (u_axis == aabb_cm_pkg::axis_t'(j)) begin
				pt[j] = sel_u_hi ? hi_q[j] : lo_q[j];
			end else begin
				pt[j] = sel_v_hi ? hi_q[j] : lo_q[j];
			end
		end
	end

	assign strobe          = em_v_q;
	assign hit             = ctrl_q.hit;
	assign normal_axis     = ctrl_q.hit ? ctrl_q.axis : aabb_cm_pkg::AXIS_X;
	assign normal_negative = ctrl_q.hit & ctrl_q.neg;
	assign point_x         = pt[aabb_cm_pkg::AXIS_X];
	assign point_y         = pt[aabb_cm_pkg::AXIS_Y];
	assign point_z         = pt[aabb_cm_pkg::AXIS_Z];
	assign depth           = ctrl_q.hit ? depth_q : '0;
	assign id_first        = ctrl_q.hit ? ida_q : '0;
	assign id_second       = ctrl_q.hit ? idb_q : '0;
	assign last            = last_now;

	// A miss is always a single transfer.
	a_miss_single: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !hit |-> last)
		else $error("miss result without last");

	// A hit burst runs without gaps and keeps its decision.
	a_burst_cont: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe && hit && (normal_axis == $past(normal_axis))
			&& (id_first == $past(id_first)))
		else $error("hit burst broken");

	// Within a burst the coordinate along the normal stays fixed; checked here for x.
	a_face_fixed: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> (normal_axis != aabb_cm_pkg::AXIS_X || point_x == $past(point_x)))
		else $error("face coordinate moved within burst");

endmodule

`default_nettype wire

FILE: rtl/aabb_contact_manifold_core.sv
// Top level of the axis-aligned box contact generator.
// Usage: drive a box pair (centers, half-extents, body ids) with start; the pair
// is taken at a rising edge where start is high and busy is low. Components are
// COORD_BITS wide two's complement, x in the low bits, then y, then z.
// Results leave on the result ports, one transfer per cycle marked by strobe;
// the receiver has no way to hold them off. A pair that overlaps on all three
// axes gives four transfers (the corners of the contact face), the last with
// last set; a pair that does not overlap gives one transfer with hit clear.
// A pair passes the three pipeline stages, then the result sequencer, before its
// first result shows.
// The core takes one pair every cycle while pairs miss; a hit holds the
// sequencer's one result port for its four transfers, and busy rises when the
// pipeline behind it is full.
// Reset clears all valid bits; no result is shown until a pair is taken.
`timescale 1ns / 1ps
`default_nettype none

module aabb_contact_manifold_core #(
	parameter int COORD_BITS = 16
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output      logic                            busy,
	input  wire logic [3*COORD_BITS-1:0]         center_a,
	input  wire logic [3*COORD_BITS-1:0]         extent_a,
	input  wire logic [3*COORD_BITS-1:0]         center_b,
	input  wire logic [3*COORD_BITS-1:0]         extent_b,
	input  wire logic [aabb_cm_pkg::ID_BITS-1:0] body_a,
	input  wire logic [aabb_cm_pkg::ID_BITS-1:0] body_b,
	output      logic                            strobe,
	output      logic                            hit,
	output      logic [1:0]                      normal_axis,
	output      logic                            normal_negative,
	output      logic signed [COORD_BITS:0]      point_x,
	output      logic signed [COORD_BITS:0]      point_y,
	output      logic signed [COORD_BITS:0]      point_z,
	output      logic [COORD_BITS-1:0]           depth,
	output      logic [aabb_cm_pkg::ID_BITS-1:0] id_first,
	output      logic [aabb_cm_pkg::ID_BITS-1:0] id_second,
	output      logic                            last
);

	localparam int NAX = aabb_cm_pkg::NUM_AXES;
	localparam int W   = COORD_BITS;

	logic adv1, adv2, adv3, em_ready;

	// Stage 1: box corners and center order.
	logic                            v_s1;
	logic signed [W:0]               lo_a_s1 [NAX];
	logic signed [W:0]               hi_a_s1 [NAX];
	logic signed [W:0]               lo_b_s1 [NAX];
	logic signed [W:0]               hi_b_s1 [NAX];
	logic [NAX-1:0]                  neg_s1;
	logic [aabb_cm_pkg::ID_BITS-1:0] ida_s1, idb_s1;

	// Stage 2: overlap interval and its length.
	logic                            v_s2;
	logic signed [W:0]               lo_a_s2 [NAX];
	logic signed [W:0]               hi_a_s2 [NAX];
	logic signed [W:0]               lo_s2 [NAX];
	logic signed [W:0]               hi_s2 [NAX];
	logic signed [W+1:0]             ov_s2 [NAX];
	logic [NAX-1:0]                  neg_s2;
	logic [aabb_cm_pkg::ID_BITS-1:0] ida_s2, idb_s2;

	// Stage 3: decision.
	logic                            v_s3;
	aabb_cm_pkg::contact_ctrl_t      ctrl_s3;
	logic signed [W:0]               face_s3;
	logic signed [W:0]               lo_s3 [NAX];
	logic signed [W:0]               hi_s3 [NAX];
	logic [W-1:0]                    depth_s3;
	logic [aabb_cm_pkg::ID_BITS-1:0] ida_s3, idb_s3;

	logic signed [W:0]               ca, ea, cb, eb;
	logic signed [W:0]               lo_a_n [NAX];
	logic signed [W:0]               hi_a_n [NAX];
	logic signed [W:0]               lo_b_n [NAX];
	logic signed [W:0]               hi_b_n [NAX];
	logic [NAX-1:0]                  neg_n;
	logic signed [W:0]               lo_n [NAX];
	logic signed [W:0]               hi_n [NAX];
	logic signed [W+1:0]             ov_n [NAX];
	aabb_cm_pkg::axis_t              best;
	logic signed [W+1:0]             best_ov;
	logic                            all_pos;

	// A stage moves when it is empty or the one after it moves.
	assign adv3 = !v_s3 || em_ready;
	assign adv2 = !v_s2 || adv3;
	assign adv1 = !v_s1 || adv2;
	assign busy = !adv1;

	always_comb begin
		ca = '0;
		ea = '0;
		cb = '0;
		eb = '0;
		for (int ax = 0; ax < NAX; ax++) begin
			ca = (W+1)'($signed(center_a[ax*W +: W]));
			ea = (W+1)'($signed(extent_a[ax*W +: W]));
			cb = (W+1)'($signed(center_b[ax*W +: W]));
			eb = (W+1)'($signed(extent_b[ax*W +: W]));
			lo_a_n[ax] = ca - ea;
			hi_a_n[ax] = ca + ea;
			lo_b_n[ax] = cb - eb;
			hi_b_n[ax] = cb + eb;
			neg_n[ax]  = ca < cb;
		end
	end

	always_comb begin
		for (int ax = 0; ax < NAX; ax++) begin
			lo_n[ax] = (lo_a_s1[ax] > lo_b_s1[ax]) ? lo_a_s1[ax] : lo_b_s1[ax];
			hi_n[ax] = (hi_a_s1[ax] < hi_b_s1[ax]) ? hi_a_s1[ax] : hi_b_s1[ax];
			ov_n[ax] = (W+2)'(hi_n[ax]) - (W+2)'(lo_n[ax]);
		end
	end

	// Least overlap; on ties x wins over y, y over z.
	always_comb begin
		all_pos = 1'b1;
		for (int ax = 0; ax < NAX; ax++) begin
			all_pos = all_pos && (ov_s2[ax] > 0);
		end
		best    = aabb_cm_pkg::AXIS_X;
		best_ov = ov_s2[aabb_cm_pkg::AXIS_X];
		if (ov_s2[aabb_cm_pkg::AXIS_Y] < best_ov) begin
			best    = aabb_cm_pkg::AXIS_Y;
			best_ov = ov_s2[aabb_cm_pkg::AXIS_Y];
		end
		if (ov_s2[aabb_cm_pkg::AXIS_Z] < best_ov) begin
			best    = aabb_cm_pkg::AXIS_Z;
			best_ov = ov_s2[aabb_cm_pkg::AXIS_Z];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= start;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			lo_a_s1 <= lo_a_n;
			hi_a_s1 <= hi_a_n;
			lo_b_s1 <= lo_b_n;
			hi_b_s1 <= hi_b_n;
			neg_s1  <= neg_n;
			ida_s1  <= body_a;
			idb_s1  <= body_b;
		end
		if (adv2) begin
			lo_a_s2 <= lo_a_s1;
			hi_a_s2 <= hi_a_s1;
			lo_s2   <= lo_n;
			hi_s2   <= hi_n;
			ov_s2   <= ov_n;
			neg_s2  <= neg_s1;
			ida_s2  <= ida_s1;
			idb_s2  <= idb_s1;
		end
		if (adv3) begin
			ctrl_s3.hit  <= all_pos;
			ctrl_s3.axis <= best;
			ctrl_s3.neg  <= neg_s2[best];
			face_s3      <= neg_s2[best] ? hi_a_s2[best] : lo_a_s2[best];
			lo_s3        <= lo_s2;
			hi_s3        <= hi_s2;
			depth_s3     <= best_ov[W-1:0];
			ida_s3       <= ida_s2;
			idb_s3       <= idb_s2;
		end
	end

	aabb_cm_emit #(
		.COORD_BITS(COORD_BITS)
	) u_emit (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (v_s3),
		.ready          (em_ready),
		.ctrl           (ctrl_s3),
		.face           (face_s3),
		.lo             (lo_s3),
		.hi             (hi_s3),
		.depth_in       (depth_s3),
		.id_a           (ida_s3),
		.id_b           (idb_s3),
		.strobe         (strobe),
		.hit            (hit),
		.normal_axis    (normal_axis),
		.normal_negative(normal_negative),
		.point_x        (point_x),
		.point_y        (point_y),
		.point_z        (point_z),
		.depth          (depth),
		.id_first       (id_first),
		.id_second      (id_second),
		.last           (last)
	);

	// A transfer taken while the pipeline is free always lands in stage 1.
	a_take_lands: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> v_s1)
		else $error("accepted pair lost at stage 1");

	// Busy only rises when every stage holds an item.
	a_busy_full: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> v_s1 && v_s2 && v_s3 && strobe)
		else $error("busy without a full pipeline");

	// A stalled stage 3 keeps its item.
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		v_s3 && !adv3 |=> v_s3 && $stable(ida_s3) && $stable(depth_s3))
		else $error("stage 3 item changed under stall");

endmodule

`default_nettype wire
